// ===== rtl/gtt_pkg.sv =====
// Shared types and constants for the gate tempo tracker.
// Item structs, register indexes, Schmitt codes. No dependencies.
`default_nettype none

package gtt_pkg;

	localparam int TIME_W      = 32;
	localparam int GATE_W      = 16;
	localparam int MULT_OUT_W  = 5;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_WEIGHT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DIVIDE_TWO    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIVIDE_THREE  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SWING_TWO     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SWING_THREE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FINE_MODE     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_GATE_HIGH     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_GATE_LOW      = 3'd7;

	localparam logic [1:0] SCH_UNKNOWN = 2'd0;
	localparam logic [1:0] SCH_LOW     = 2'd1;
	localparam logic [1:0] SCH_HIGH    = 2'd2;

	localparam logic [8:0]        WEIGHT_ONE = 9'd256;
	localparam logic [2:0]        MISS_LIMIT = 3'd4;
	localparam logic [TIME_W-1:0] TICK_Q8    = 32'd256;
	localparam logic [11:0]       FINE_BASE  = 12'd768;

	typedef struct packed {
		logic signed [GATE_W-1:0] gate_level;
		logic                     gate_connected;
	} in_item_t;

	typedef struct packed {
		logic                  trig_main;
		logic                  trig_two;
		logic                  trig_three;
		logic [TIME_W-1:0]     period_out;
		logic                  beat_seen;
		logic [MULT_OUT_W-1:0] matched_multiple;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/gtt_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
// Divides a TIME_W-bit dividend by a narrow divisor; uses gtt_pkg.
`default_nettype none

module gtt_divider #(
	parameter int DIVISOR_W = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [gtt_pkg::TIME_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]      divisor,
	output logic                           done,
	output logic [gtt_pkg::TIME_W-1:0]     quotient
);
	import gtt_pkg::*;

	localparam int CW = $clog2(TIME_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [TIME_W-1:0] quo_q;
	logic [DIVISOR_W-1:0] rem_q;

	logic [DIVISOR_W:0] part;
	logic [DIVISOR_W:0] diff;
	logic               ge;

	always_comb begin
		part = {rem_q, quo_q[TIME_W-1]};
		diff = part - {1'b0, divisor};
		ge   = part >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : part[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/gate_tempo_tracker_unit.sv =====
// Path per item: a disconnected gate goes straight to the result; otherwise the fire
// checks run, and a beat goes on to the multiple search (skipped at the miss limit), the
// divider on a match, and the smoothing. One item at a time; the multiple search on the
// shared 32x32 multiplier and the divider set the length. A finished item waits
// in the output register while the next one is accepted.
// Reset: registers to their defaults, all timers and pulses cleared, Schmitt unknown.
`default_nettype none

module gate_tempo_tracker_unit #(
	parameter int PULSE_TICKS  = 480,
	parameter int MAX_MULTIPLE = 19
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [gtt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [gtt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire gtt_pkg::in_item_t              in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output gtt_pkg::out_item_t                  out_item
);
	import gtt_pkg::*;

	localparam int MW  = $clog2(MAX_MULTIPLE + 1);
	localparam int MPW = TIME_W + MW;
	localparam int PW  = $clog2(PULSE_TICKS + 1);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_FA1  = 5'd1;
	localparam logic [4:0] ST_FB1  = 5'd2;
	localparam logic [4:0] ST_FC1  = 5'd3;
	localparam logic [4:0] ST_FB2  = 5'd4;
	localparam logic [4:0] ST_FC2  = 5'd5;
	localparam logic [4:0] ST_PPM  = 5'd6;
	localparam logic [4:0] ST_PPS  = 5'd7;
	localparam logic [4:0] ST_SD   = 5'd8;
	localparam logic [4:0] ST_SM   = 5'd9;
	localparam logic [4:0] ST_SC   = 5'd10;
	localparam logic [4:0] ST_DIV  = 5'd11;
	localparam logic [4:0] ST_SMA  = 5'd12;
	localparam logic [4:0] ST_SMB  = 5'd13;
	localparam logic [4:0] ST_SMC  = 5'd14;
	localparam logic [4:0] ST_SMD  = 5'd15;
	localparam logic [4:0] ST_FIN  = 5'd16;

	// configuration
	logic [8:0]               weight_q;
	logic [3:0]               div2_q, div3_q;
	logic [9:0]               swing2_q, swing3_q;
	logic                     fine_q;
	logic signed [GATE_W-1:0] gate_hi_q, gate_lo_q;

	// tracker state
	logic [4:0]        state_q;
	logic [1:0]        sch_q;
	logic [2:0]        miss_q;
	logic [TIME_W:0]   bt_q;
	logic [TIME_W-1:0] ft_q [3];
	logic [TIME_W-1:0] period_q;
	logic [PW-1:0]     pulse_q [3];

	// per-item working registers
	logic signed [GATE_W-1:0] level_q;
	logic              seen_q;
	logic [MW-1:0]     matched_q;
	logic [MW-1:0]     m_q;
	logic [MPW-1:0]    mp_q;
	logic [MPW-1:0]    ad_q;
	logic              lt_q;
	logic [63:0]       pp_q;
	logic [TIME_W-1:0] cand_q;
	logic [40:0]       a_q;
	logic [63:0]       mul_q;
	logic              out_valid_q;
	out_item_t         out_q;

	// shared multiplier operands
	logic [TIME_W-1:0] mul_a, mul_b;

	logic [8:0]        w_eff;
	logic [3:0]        d2_eff, d3_eff;
	logic [11:0]       e2, e3;
	logic              sub_fire;
	logic [1:0]        sch_next;
	logic              edge_det;
	logic              bt_pos;
	logic [TIME_W-1:0] t_val;
	logic [MPW-1:0]    t_ext;
	logic [66:0]       five_sq;
	logic              match;
	logic [41:0]       smooth_sum;
	logic [TIME_W+1:0] bt_sub;
	logic [TIME_W+1:0] bt_add;
	logic [TIME_W:0]   ft_sum [3];
	logic              div_start;
	logic              div_done;
	logic [TIME_W-1:0] div_quo;
	logic              out_free;

	always_comb begin
		w_eff  = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
		d2_eff = (div2_q == 4'd0) ? 4'd1 : div2_q;
		d3_eff = (div3_q == 4'd0) ? 4'd1 : div3_q;
		e2     = fine_q ? (FINE_BASE + {2'b00, swing2_q}) : {swing2_q, 2'b00};
		e3     = fine_q ? (FINE_BASE + {2'b00, swing3_q}) : {swing3_q, 2'b00};
		sub_fire = {a_q[35:0], 10'b0} > {2'b00, mul_q[43:0]};
		t_val  = bt_q[TIME_W-1:0];
		t_ext  = MPW'(t_val);
		bt_pos = !bt_q[TIME_W] && (t_val != '0);
		five_sq = {1'b0, mul_q, 2'b00} + {3'b000, mul_q};
		match  = lt_q && (five_sq < {3'b000, pp_q});
		smooth_sum = {1'b0, a_q} + {1'b0, mul_q[40:0]} + 42'd128;
		bt_sub = {bt_q[TIME_W], bt_q} - {2'b00, period_q};
		bt_add = {bt_q[TIME_W], bt_q} + {2'b00, TICK_Q8};
		for (int k = 0; k < 3; k++) begin
			ft_sum[k] = {1'b0, ft_q[k]} + {1'b0, TICK_Q8};
		end
		div_start = (state_q == ST_SC) && match;
		out_free  = !out_valid_q || !out_stall;
	end

	// Schmitt trigger
	always_comb begin
		sch_next = sch_q;
		edge_det = 1'b0;
		case (sch_q)
			SCH_LOW: begin
				if (level_q >= gate_hi_q) begin
					sch_next = SCH_HIGH;
					edge_det = 1'b1;
				end
			end
			SCH_HIGH: begin
				if (level_q <= gate_lo_q) sch_next = SCH_LOW;
			end
			default: begin
				if (level_q >= gate_hi_q) sch_next = SCH_HIGH;
				else if (level_q <= gate_lo_q) sch_next = SCH_LOW;
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FA1: begin
				mul_a = ft_q[1];
				mul_b = TIME_W'(d2_eff);
			end
			ST_FB1: begin
				mul_a = period_q;
				mul_b = TIME_W'(e2);
			end
			ST_FC1: begin
				mul_a = ft_q[2];
				mul_b = TIME_W'(d3_eff);
			end
			ST_FB2: begin
				mul_a = period_q;
				mul_b = TIME_W'(e3);
			end
			ST_PPM: begin
				mul_a = period_q;
				mul_b = period_q;
			end
			ST_SM: begin
				mul_a = ad_q[TIME_W-1:0];
				mul_b = ad_q[TIME_W-1:0];
			end
			ST_SMA: begin
				mul_a = period_q;
				mul_b = TIME_W'(WEIGHT_ONE - w_eff);
			end
			ST_SMB: begin
				mul_a = cand_q;
				mul_b = TIME_W'(w_eff);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	gtt_divider #(
		.DIVISOR_W(MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (t_val),
		.divisor  (m_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q  <= 9'd128;
			div2_q    <= 4'd2;
			div3_q    <= 4'd3;
			swing2_q  <= 10'd256;
			swing3_q  <= 10'd256;
			fine_q    <= 1'b0;
			gate_hi_q <= 16'sd2048;
			gate_lo_q <= 16'sd0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SMOOTH_WEIGHT: weight_q  <= cfg_data[8:0];
				REG_DIVIDE_TWO:    div2_q    <= cfg_data[3:0];
				REG_DIVIDE_THREE:  div3_q    <= cfg_data[3:0];
				REG_SWING_TWO:     swing2_q  <= cfg_data[9:0];
				REG_SWING_THREE:   swing3_q  <= cfg_data[9:0];
				REG_FINE_MODE:     fine_q    <= cfg_data[0];
				REG_GATE_HIGH:     gate_hi_q <= cfg_data;
				REG_GATE_LOW:      gate_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sch_q       <= SCH_UNKNOWN;
			miss_q      <= '0;
			bt_q        <= '0;
			period_q    <= '0;
			seen_q      <= 1'b0;
			matched_q   <= '0;
			m_q         <= '0;
			for (int k = 0; k < 3; k++) begin
				ft_q[k]    <= '0;
				pulse_q[k] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						seen_q    <= 1'b0;
						matched_q <= '0;
						state_q   <= in_item.gate_connected ? ST_FA1 : ST_FIN;
					end
				end
				ST_FA1: begin
					if (ft_q[0] > period_q) begin
						pulse_q[0] <= PW'(PULSE_TICKS);
						ft_q[0]    <= '0;
					end
					state_q <= ST_FB1;
				end
				ST_FB1: state_q <= ST_FC1;
				ST_FC1: begin
					if (sub_fire) begin
						pulse_q[1] <= PW'(PULSE_TICKS);
						ft_q[1]    <= '0;
					end
					state_q <= ST_FB2;
				end
				ST_FB2: state_q <= ST_FC2;
				ST_FC2: begin
					if (sub_fire) begin
						pulse_q[2] <= PW'(PULSE_TICKS);
						ft_q[2]    <= '0;
					end
					sch_q <= sch_next;
					m_q   <= MW'(1);
					if (edge_det && bt_pos) begin
						if (miss_q < MISS_LIMIT) begin
							state_q <= ST_PPM;
						end else begin
							miss_q  <= '0;
							state_q <= ST_SMA;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_PPM: state_q <= ST_PPS;
				ST_PPS: state_q <= ST_SD;
				ST_SD:  state_q <= ST_SM;
				ST_SM:  state_q <= ST_SC;
				ST_SC: begin
					if (match) begin
						matched_q <= m_q;
						miss_q    <= (m_q == MW'(1)) ? 3'd0 : miss_q + 3'd1;
						state_q   <= ST_DIV;
					end else if (m_q == MW'(MAX_MULTIPLE)) begin
						miss_q  <= '0;
						state_q <= ST_SMA;
					end else begin
						m_q     <= m_q + MW'(1);
						state_q <= ST_SD;
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_SMA;
				end
				ST_SMA: state_q <= ST_SMB;
				ST_SMB: state_q <= ST_SMC;
				ST_SMC: begin
					period_q <= smooth_sum[39:8];
					state_q  <= ST_SMD;
				end
				ST_SMD: begin
					if (bt_sub[TIME_W+1] && !bt_sub[TIME_W]) begin
						bt_q <= {1'b1, {TIME_W{1'b0}}};
					end else begin
						bt_q <= bt_sub[TIME_W:0];
					end
					for (int k = 0; k < 3; k++) begin
						ft_q[k]    <= '0;
						pulse_q[k] <= PW'(PULSE_TICKS);
					end
					seen_q  <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						if (!bt_add[TIME_W+1] && bt_add[TIME_W]) begin
							bt_q <= {1'b0, {TIME_W{1'b1}}};
						end else begin
							bt_q <= bt_add[TIME_W:0];
						end
						for (int k = 0; k < 3; k++) begin
							ft_q[k] <= ft_sum[k][TIME_W] ? '1 : ft_sum[k][TIME_W-1:0];
							if (pulse_q[k] != '0) pulse_q[k] <= pulse_q[k] - PW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) level_q <= in_item.gate_level;
		if (state_q == ST_FC2) begin
			mp_q   <= MPW'(period_q);
			cand_q <= t_val;
		end
		if (state_q == ST_SC && !match) mp_q <= mp_q + MPW'(period_q);
		if (state_q == ST_SC && !match && m_q == MW'(MAX_MULTIPLE)) cand_q <= t_val;
		if (state_q == ST_DIV && div_done) cand_q <= div_quo;
		if (state_q == ST_PPS) pp_q <= mul_q;
		if (state_q == ST_SD) ad_q <= (mp_q >= t_ext) ? (mp_q - t_ext) : (t_ext - mp_q);
		if (state_q == ST_SM) lt_q <= ad_q < MPW'(period_q);
		if (state_q == ST_FB1 || state_q == ST_FB2 || state_q == ST_SMB) a_q <= mul_q[40:0];
		if (state_q == ST_FIN && out_free) begin
			out_q.trig_main        <= pulse_q[0] != '0;
			out_q.trig_two         <= pulse_q[1] != '0;
			out_q.trig_three       <= pulse_q[2] != '0;
			out_q.period_out       <= period_q;
			out_q.beat_seen        <= seen_q;
			out_q.matched_multiple <= MULT_OUT_W'(matched_q);
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ===== rtl/gtt_checker.sv =====
// Port-level checks for gate_tempo_tracker_unit, attached by bind.
// Depends on gtt_pkg for the item types.
`default_nettype none

module gtt_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire gtt_pkg::out_item_t out_item
);
	import gtt_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result item changed");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item with no item in work");

	a_match_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.matched_multiple != '0) |-> out_item.beat_seen)
		else $error("matched multiple without a beat");

	a_beat_fires_all: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.beat_seen |->
			out_item.trig_main && out_item.trig_two && out_item.trig_three)
		else $error("beat did not restart all pulses");

endmodule

bind gate_tempo_tracker_unit gtt_checker u_gtt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

// ===== tb/tb_gate_tempo_tracker_unit.sv =====
// Self-checking bench for gate_tempo_tracker_unit: a directed stimulus table, then
// seven register settings driven with random gate trains, noise and disconnects.
// Every result is compared with a tick-accurate model held here. Needs gtt_pkg.
`default_nettype none

module tb_gate_tempo_tracker_unit;
	import gtt_pkg::*;

	localparam int PULSE_LEN   = 480;
	localparam int MULT_MAX    = 19;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 140;
	localparam int LONG_PHASE  = 4;
	localparam int DIR_ROWS    = 20;
	localparam int MAX_SHOWN   = 100;
	localparam longint BEAT_MAX = 64'sd4294967295;
	localparam longint BEAT_MIN = -64'sd4294967296;

	typedef struct {
		int          level;
		bit          conn;
		bit          typed;
		bit          want_main;
		bit          want_two;
		bit          want_three;
		int unsigned want_period;
		bit          want_seen;
		int          want_mult;
	} dir_row_t;

	typedef struct {
		int weight;
		int div2;
		int div3;
		int sw2;
		int sw3;
		int fine;
		int hi;
		int lo;
	} cfg_set_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	in_item_t               in_item;
	logic                   out_valid;
	logic                   out_stall;
	out_item_t              out_item;

	// tracker model state and register copies
	logic [1:0]         sch_q;
	logic [2:0]         misses_q;
	longint             beat_clk_q;
	logic [31:0]        fire_clk_q [3];
	logic [31:0]        period_q;
	int                 pulse_q [3];
	logic [8:0]         weight_q;
	logic [3:0]         div_q [3];
	logic [9:0]         swing_q [3];
	logic               fine_q;
	logic signed [15:0] gate_hi_q;
	logic signed [15:0] gate_lo_q;

	out_item_t predicted_ticks [$];
	int        mismatch_count;
	int        items_sent;
	int        results_seen;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{0,      0, 1, 0, 0, 0, 0,   0, 0},
		'{-32768, 1, 1, 1, 1, 1, 0,   0, 0},
		'{32767,  1, 1, 1, 1, 1, 256, 1, 0},
		'{0,      1, 0, 0, 0, 0, 0,   0, 0},
		'{2048,   1, 1, 1, 1, 1, 256, 1, 3},
		'{0,      0, 0, 0, 0, 0, 0,   0, 0},
		'{-1,     1, 0, 0, 0, 0, 0,   0, 0},
		'{2047,   1, 0, 0, 0, 0, 0,   0, 0},
		'{32767,  0, 0, 0, 0, 0, 0,   0, 0},
		'{1,      1, 0, 0, 0, 0, 0,   0, 0},
		'{2048,   1, 0, 0, 0, 0, 0,   0, 0},
		'{0,      1, 0, 0, 0, 0, 0,   0, 0},
		'{4096,   1, 0, 0, 0, 0, 0,   0, 0},
		'{100,    1, 0, 0, 0, 0, 0,   0, 0},
		'{-32768, 1, 0, 0, 0, 0, 0,   0, 0},
		'{32767,  1, 0, 0, 0, 0, 0,   0, 0},
		'{0,      1, 0, 0, 0, 0, 0,   0, 0},
		'{2048,   1, 0, 0, 0, 0, 0,   0, 0},
		'{-32768, 0, 0, 0, 0, 0, 0,   0, 0},
		'{32767,  1, 0, 0, 0, 0, 0,   0, 0}
	};

	cfg_set_t settings_tab [PHASES-1] = '{
		'{128, 2, 3, 256,  256,  0, 2048,   0},
		'{256, 1, 8, 512,  0,    1, 1000,   -1000},
		'{0,   8, 1, 0,    512,  0, 32767,  -32768},
		'{511, 0, 15, 1023, 300, 1, -100,   -200},
		'{64,  5, 7, 384,  128,  0, 2048,   0},
		'{300, 4, 0, 200,  1023, 1, -32768, 32767}
	};

	gate_tempo_tracker_unit #(
		.PULSE_TICKS (PULSE_LEN),
		.MAX_MULTIPLE(MULT_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void reset_tracker();
		weight_q   = 9'd128;
		div_q[0]   = 4'd1;
		div_q[1]   = 4'd2;
		div_q[2]   = 4'd3;
		swing_q[0] = 10'd256;
		swing_q[1] = 10'd256;
		swing_q[2] = 10'd256;
		fine_q     = 1'b0;
		gate_hi_q  = 16'sd2048;
		gate_lo_q  = 16'sd0;
		sch_q      = SCH_UNKNOWN;
		misses_q   = 3'd0;
		beat_clk_q = 0;
		period_q   = 32'd0;
		for (int k = 0; k < 3; k++) begin
			fire_clk_q[k] = 32'd0;
			pulse_q[k]    = 0;
		end
	endfunction

	function automatic bit subdiv_due(int k);
		longint unsigned d, e, lhs, rhs;
		d   = (div_q[k] == 4'd0) ? 64'd1 : 64'(div_q[k]);
		e   = fine_q ? 64'(FINE_BASE) + 64'(swing_q[k]) : 64'd4 * 64'(swing_q[k]);
		lhs = 64'(fire_clk_q[k]) * d * 64'd1024;
		rhs = 64'(period_q) * e;
		return lhs > rhs;
	endfunction

	// true when t lies within period/sqrt(5) of m periods
	function automatic bit near_beat(longint t, int m);
		longint unsigned p, ad, pp, lim;
		longint          d;
		p = 64'(period_q);
		d = t - longint'(m) * longint'(period_q);
		ad = (d < 0) ? -d : d;
		if (ad >= p)
			return 1'b0;
		pp  = p * p;
		lim = pp / 64'd5 + ((pp % 64'd5 != 64'd0) ? 64'd1 : 64'd0);
		return ad * ad < lim;
	endfunction

	function automatic out_item_t advance_tracker(in_item_t it);
		out_item_t       r;
		bit              rise, seen;
		int              matched;
		longint unsigned cand, w, np;
		rise    = 1'b0;
		seen    = 1'b0;
		matched = 0;
		if (it.gate_connected) begin
			if (fire_clk_q[0] > period_q) begin
				pulse_q[0]    = PULSE_LEN;
				fire_clk_q[0] = 32'd0;
			end
			for (int k = 1; k < 3; k++)
				if (subdiv_due(k)) begin
					pulse_q[k]    = PULSE_LEN;
					fire_clk_q[k] = 32'd0;
				end
			case (sch_q)
				SCH_LOW: if (it.gate_level >= gate_hi_q) begin
					sch_q = SCH_HIGH;
					rise  = 1'b1;
				end
				SCH_HIGH: if (it.gate_level <= gate_lo_q)
					sch_q = SCH_LOW;
				default: if (it.gate_level >= gate_hi_q)
					sch_q = SCH_HIGH;
				else if (it.gate_level <= gate_lo_q)
					sch_q = SCH_LOW;
			endcase
			if (rise && beat_clk_q > 0) begin
				cand = beat_clk_q;
				w    = (weight_q > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(weight_q);
				for (int m = 1; matched == 0 && m <= MULT_MAX; m++)
					if (misses_q < MISS_LIMIT && near_beat(beat_clk_q, m)) begin
						cand     = beat_clk_q / m;
						misses_q = (m == 1) ? 3'd0 : misses_q + 3'd1;
						matched  = m;
					end
				if (matched == 0)
					misses_q = 3'd0;
				np         = ((64'd256 - w) * 64'(period_q) + w * cand + 64'd128) >> 8;
				period_q   = np[31:0];
				beat_clk_q = beat_clk_q - longint'(period_q);
				if (beat_clk_q < BEAT_MIN)
					beat_clk_q = BEAT_MIN;
				for (int k = 0; k < 3; k++) begin
					fire_clk_q[k] = 32'd0;
					pulse_q[k]    = PULSE_LEN;
				end
				seen = 1'b1;
			end
		end
		beat_clk_q = beat_clk_q + longint'(TICK_Q8);
		if (beat_clk_q > BEAT_MAX)
			beat_clk_q = BEAT_MAX;
		for (int k = 0; k < 3; k++)
			fire_clk_q[k] = (fire_clk_q[k] > 32'hFFFF_FFFF - TICK_Q8) ?
				32'hFFFF_FFFF : fire_clk_q[k] + TICK_Q8;
		r.trig_main  = (pulse_q[0] != 0);
		r.trig_two   = (pulse_q[1] != 0);
		r.trig_three = (pulse_q[2] != 0);
		for (int k = 0; k < 3; k++)
			if (pulse_q[k] != 0)
				pulse_q[k]--;
		r.period_out       = period_q;
		r.beat_seen        = seen;
		r.matched_multiple = 5'(matched);
		return r;
	endfunction

	function automatic out_item_t typed_result(dir_row_t row);
		out_item_t r;
		r.trig_main        = row.want_main;
		r.trig_two         = row.want_two;
		r.trig_three       = row.want_three;
		r.period_out       = row.want_period;
		r.beat_seen        = row.want_seen;
		r.matched_multiple = 5'(row.want_mult);
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(16, 120);
	endfunction

	function automatic in_item_t train_item(bit up);
		in_item_t it;
		int       lvl;
		if (up)
			lvl = int'(gate_hi_q) + (($urandom_range(0, 3) == 0) ? 0 :
				int'($urandom_range(0, 32767 - int'(gate_hi_q))));
		else
			lvl = int'(gate_lo_q) - (($urandom_range(0, 3) == 0) ? 0 :
				int'($urandom_range(0, int'(gate_lo_q) + 32768)));
		it.gate_level     = 16'(lvl);
		it.gate_connected = ($urandom_range(0, 39) != 0);
		return it;
	endfunction

	function automatic cfg_set_t random_settings();
		cfg_set_t s;
		s.weight = $urandom_range(0, 511);
		s.div2   = $urandom_range(0, 15);
		s.div3   = $urandom_range(0, 15);
		s.sw2    = $urandom_range(0, 1023);
		s.sw3    = $urandom_range(0, 1023);
		s.fine   = $urandom_range(0, 1);
		s.hi     = int'($urandom_range(0, 8000)) - 2000;
		s.lo     = s.hi - int'($urandom_range(0, 6000));
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < MAX_SHOWN)
			$display("%0t result %0d: %s", $time, results_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_ticks.size() == 0)
				report_mismatch("result with no item outstanding");
			else begin
				want = predicted_ticks.pop_front();
				check_field("trig_main", 32'(out_item.trig_main), 32'(want.trig_main));
				check_field("trig_two", 32'(out_item.trig_two), 32'(want.trig_two));
				check_field("trig_three", 32'(out_item.trig_three), 32'(want.trig_three));
				check_field("period_out", out_item.period_out, want.period_out);
				check_field("beat_seen", 32'(out_item.beat_seen), 32'(want.beat_seen));
				check_field("matched_multiple", 32'(out_item.matched_multiple),
					32'(want.matched_multiple));
			end
			results_seen++;
		end
	end

	initial begin
		int hold, free_run;
		hold      = 0;
		free_run  = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (free_run > 0)
					free_run--;
				else begin
					hold     = pick_gap();
					free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) :
						$urandom_range(0, 6);
				end
			end
		end
	end

	task automatic send_item(in_item_t it, int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		predicted_ticks.push_back(advance_tracker(it));
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (predicted_ticks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 16'(value);
		case (idx)
			REG_SMOOTH_WEIGHT: weight_q   = 9'(value);
			REG_DIVIDE_TWO:    div_q[1]   = 4'(value);
			REG_DIVIDE_THREE:  div_q[2]   = 4'(value);
			REG_SWING_TWO:     swing_q[1] = 10'(value);
			REG_SWING_THREE:   swing_q[2] = 10'(value);
			REG_FINE_MODE:     fine_q     = 1'(value);
			REG_GATE_HIGH:     gate_hi_q  = 16'(value);
			default:           gate_lo_q  = 16'(value);
		endcase
	endtask

	task automatic apply_settings(cfg_set_t s);
		write_reg(REG_SMOOTH_WEIGHT, s.weight);
		write_reg(REG_DIVIDE_TWO, s.div2);
		write_reg(REG_DIVIDE_THREE, s.div3);
		write_reg(REG_SWING_TWO, s.sw2);
		write_reg(REG_SWING_THREE, s.sw3);
		write_reg(REG_FINE_MODE, s.fine);
		write_reg(REG_GATE_HIGH, s.hi);
		write_reg(REG_GATE_LOW, s.lo);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// regular gate pulses, with skipped beats, jitter and tempo changes
	task automatic beat_train(bit calm);
		int n, n2, beats, hw, span;
		n     = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 24) : $urandom_range(25, 80);
		beats = (n > 24) ? $urandom_range(3, 5) : $urandom_range(3, 10);
		hw    = $urandom_range(1, n - 1);
		n2    = (n <= 24 && $urandom_range(0, 4) == 0) ? n * $urandom_range(2, 3) : n;
		for (int b = 0; b < beats; b++) begin
			span = (b >= beats / 2) ? n2 : n;
			case ($urandom_range(0, 19))
				0, 1, 2: if (span <= 40) span = span * 2;
				3, 4:    span = span + 1;
				5:       span = span - 1;
				6:       span = span / 2;
				default: ;
			endcase
			if (span <= hw)
				span = hw + 1;
			for (int i = 0; i < span; i++)
				send_item(train_item(i < hw), calm ? 0 : pick_gap());
		end
	endtask

	task automatic run_phase(int p);
		int       mark, r, cnt;
		bit       calm;
		in_item_t it;
		mark = items_sent;
		if (p == LONG_PHASE)
			repeat (PULSE_LEN + 20) begin
				it.gate_level     = 16'($urandom);
				it.gate_connected = 1'b0;
				send_item(it, 0);
			end
		while (items_sent - mark < PHASE_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			r    = $urandom_range(0, 99);
			cnt  = $urandom_range(5, 30);
			if (r < 3) begin
				idle_input();
				drain_results();
			end else if (r < 68)
				beat_train(calm);
			else
				repeat (cnt) begin
					it.gate_level     = 16'($urandom);
					it.gate_connected = 1'b1;
					if (r < 82)
						it.gate_connected = ($urandom_range(0, 4) != 0);
					else if (r < 94)
						it.gate_connected = 1'b0;
					else
						case ($urandom_range(0, 3))
							0:       it.gate_level = gate_hi_q;
							1:       it.gate_level = gate_hi_q - 16'sd1;
							2:       it.gate_level = gate_lo_q;
							default: it.gate_level = gate_lo_q + 16'sd1;
						endcase
					send_item(it, calm ? 0 : pick_gap());
				end
		end
	endtask

	initial begin
		cfg_set_t s;
		in_item_t it;
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		in_item        = '0;
		mismatch_count = 0;
		items_sent     = 0;
		results_seen   = 0;
		reset_tracker();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			it.gate_level     = 16'(dir_tab[i].level);
			it.gate_connected = dir_tab[i].conn;
			send_item(it, pick_gap());
			if (dir_tab[i].typed)
				predicted_ticks[predicted_ticks.size() - 1] = typed_result(dir_tab[i]);
		end

		for (int p = 0; p < PHASES; p++) begin
			idle_input();
			drain_results();
			s = (p < PHASES - 1) ? settings_tab[p] : random_settings();
			apply_settings(s);
			run_phase(p);
		end

		idle_input();
		drain_results();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
